// File: design/hcwt_pkg.sv
`default_nettype none

package hcwt_pkg;

  // widths
  localparam int ADC_BITS_DEF = 10;
  localparam int TGT_W        = 26;
  localparam int QUEUE_DEPTH  = 2;

  function automatic int num_width(input int adc_bits);
    return (adc_bits + 11 > 21) ? adc_bits + 11 : 21;
  endfunction

  function automatic int div_width(input int num_w);
    return (num_w > TGT_W) ? num_w : TGT_W;
  endfunction

  // func, night flag, two set values, three numerators
  function automatic int ent_width(input int num_w);
    return 2 + 2 * 8 + 3 * num_w;
  endfunction

  localparam int NUM_W_DEF = num_width(ADC_BITS_DEF);
  localparam int DIV_W_DEF = div_width(NUM_W_DEF);

  // sensor lines at x1000 scale
  localparam int OUT_GAIN   = 652;
  localparam int OUT_OFS    = 326440;
  localparam int DAY_GAIN   = 70;
  localparam int DAY_OFS    = 23579;
  localparam int NIGHT_GAIN = 38;
  localparam int NIGHT_OFS  = 1164;

  // constant divisors and their reciprocals scaled by 2^32
  localparam int CONV_DIV  = 1000;
  localparam int CURVE_DIV = 10;
  localparam int DVS_W     = 10;
  localparam longint unsigned RECIP_ONE = 64'd1 << 32;
  localparam logic [31:0] RECIP_CONV  = 32'(RECIP_ONE / CONV_DIV);
  localparam logic [31:0] RECIP_CURVE = 32'(RECIP_ONE / CURVE_DIV);

  // configuration registers
  localparam int CFG_N      = 5;
  localparam int CFG_IDX_W  = $clog2(CFG_N);
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TREF  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WMIN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WMAX  = CFG_IDX_W'(4);

  localparam logic [15:0] COEF_RST  = 16'd15;
  localparam logic [15:0] SHIFT_RST = 16'd200;
  localparam logic [7:0]  TREF_RST  = 8'd20;
  localparam logic [7:0]  WMIN_RST  = 8'd20;
  localparam logic [7:0]  WMAX_RST  = 8'd80;

  typedef struct packed {
    logic [15:0] coef;
    logic [15:0] shift;
    logic [7:0]  tref;
    logic [7:0]  wmin;
    logic [7:0]  wmax;
  } cfg_t;

  typedef enum logic [0:0] {
    DIV_CONV,
    DIV_CURVE
  } div_sel_t;

  typedef enum logic [1:0] {
    SRC_HEAD,
    SRC_DAY,
    SRC_NIGHT,
    SRC_CURVE
  } div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV1,
    ST_CONV2,
    ST_CONV3,
    ST_CONV4,
    ST_CONV5,
    ST_MULT,
    ST_TDIV,
    ST_TW1,
    ST_TW2,
    ST_TDONE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic     pop;
    logic     ld_set;
    div_src_t src;
    div_sel_t sel;
    logic     ld_outside;
    logic     ld_day;
    logic     ld_night;
    logic     ld_tnum;
    logic     ld_target;
    logic     ld_out;
  } back_ctl_t;

endpackage

`default_nettype wire

// File: design/hcwt_front.sv
`default_nettype none

module hcwt_front
  import hcwt_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int NUM_W    = NUM_W_DEF
) (
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        in_func,
  input  wire logic [ADC_BITS-1:0]         in_outside_adc,
  input  wire logic [ADC_BITS-1:0]         in_day_trim_adc,
  input  wire logic [ADC_BITS-1:0]         in_night_trim_adc,
  input  wire logic                        in_night_mode,
  input  wire logic signed [7:0]           in_set_day,
  input  wire logic signed [7:0]           in_set_night,
  input  wire logic                        q_full,
  output logic                             q_wr,
  output logic [ent_width(NUM_W)-1:0]      q_data
);

  logic [NUM_W-1:0] num_out;
  logic [NUM_W-1:0] num_day;
  logic [NUM_W-1:0] num_night;

  // item taken when the queue has room
  assign full = q_full;
  assign q_wr = push && !q_full;

  // numerators of the three sensor lines, two's complement
  assign num_out   = NUM_W'(OUT_OFS) - NUM_W'(OUT_GAIN * int'(in_outside_adc));
  assign num_day   = NUM_W'(DAY_GAIN * int'(in_day_trim_adc)) - NUM_W'(DAY_OFS);
  assign num_night = NUM_W'(NIGHT_GAIN * int'(in_night_trim_adc)) - NUM_W'(NIGHT_OFS);

  // queue entry
  assign q_data = {in_func, in_night_mode, in_set_day, in_set_night,
                   num_out, num_day, num_night};

endmodule

`default_nettype wire

// File: design/hcwt_queue.sv
`default_nettype none

module hcwt_queue
  import hcwt_pkg::*;
#(
  parameter int WIDTH = ent_width(NUM_W_DEF),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count_r == (PTR_W + 1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_en   = wr && !full;
  assign rd_en   = rd && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + (PTR_W + 1)'(wr_en) - (PTR_W + 1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: design/hcwt_div.sv
`default_nettype none

module hcwt_div
  import hcwt_pkg::*;
#(
  parameter int DIV_W = DIV_W_DEF
) (
  input  wire logic                    clk,
  input  wire div_sel_t                sel,
  input  wire logic signed [DIV_W-1:0] x,
  output logic signed [DIV_W-1:0]      q
);

  logic [DIV_W-1:0]       mag;
  logic [DIV_W-1:0]       m1_r;
  logic [DIV_W-1:0]       m2_r;
  logic                   neg1_r;
  logic                   neg2_r;
  div_sel_t               sel1_r;
  div_sel_t               sel2_r;
  logic [31:0]            recip;
  logic [DIV_W+31:0]      prod;
  logic [DIV_W-1:0]       q0_r;
  logic [DVS_W-1:0]       dvs;
  logic [DIV_W+DVS_W-1:0] qd;
  logic [DIV_W:0]         rem;
  logic [DIV_W-1:0]       qc;
  logic [DIV_W-1:0]       q_r;

  // stage 1: sign and magnitude, truncation toward zero works on the magnitude
  assign mag = x[DIV_W-1] ? DIV_W'(-x) : DIV_W'(x);

  always_ff @(posedge clk) begin
    m1_r   <= mag;
    neg1_r <= x[DIV_W-1];
    sel1_r <= sel;
  end

  // stage 2: reciprocal multiply, estimate is low by at most one
  assign recip = (sel1_r == DIV_CONV) ? RECIP_CONV : RECIP_CURVE;
  assign prod  = (DIV_W + 32)'(m1_r) * (DIV_W + 32)'(recip);

  always_ff @(posedge clk) begin
    q0_r   <= prod[DIV_W+31:32];
    m2_r   <= m1_r;
    neg2_r <= neg1_r;
    sel2_r <= sel1_r;
  end

  // stage 3: one remainder check, then restore the sign
  assign dvs = (sel2_r == DIV_CONV) ? DVS_W'(CONV_DIV) : DVS_W'(CURVE_DIV);
  assign qd  = (DIV_W + DVS_W)'(q0_r) * (DIV_W + DVS_W)'(dvs);
  assign rem = {1'b0, m2_r} - qd[DIV_W:0];
  assign qc  = (rem >= (DIV_W + 1)'(dvs)) ? q0_r + DIV_W'(1) : q0_r;

  always_ff @(posedge clk) begin
    q_r <= neg2_r ? DIV_W'(-qc) : qc;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: design/hcwt_back.sv
`default_nettype none

module hcwt_back
  import hcwt_pkg::*;
#(
  parameter int NUM_W = NUM_W_DEF,
  parameter int DIV_W = DIV_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cfg_t                        cfg,
  input  wire logic                        q_empty,
  input  wire logic [ent_width(NUM_W)-1:0] q_data,
  output logic                             q_pop,
  output logic signed [DIV_W-1:0]          div_x,
  output div_sel_t                         div_sel,
  input  wire logic signed [DIV_W-1:0]     div_q,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [7:0]                out_water_target,
  output logic signed [7:0]                out_day_desired,
  output logic signed [7:0]                out_night_desired,
  output logic signed [7:0]                out_outside_temp
);

  function automatic logic [7:0] sat8(input logic signed [31:0] v);
    if (v < -32'sd128) begin
      return 8'h80;
    end
    if (v > 32'sd127) begin
      return 8'h7f;
    end
    return v[7:0];
  endfunction

  back_state_t state_r;
  back_state_t state_nxt;
  back_ctl_t   ctl;

  // queue head fields
  logic                    h_func;
  logic                    h_night;
  logic [7:0]              h_set_day;
  logic [7:0]              h_set_night;
  logic [NUM_W-1:0]        h_num_out;
  logic [NUM_W-1:0]        h_num_day;
  logic [NUM_W-1:0]        h_num_night;

  // item under way
  logic                    cur_night_r;
  logic [NUM_W-1:0]        cur_num_day_r;
  logic [NUM_W-1:0]        cur_num_night_r;
  logic signed [7:0]       day_r;
  logic signed [TGT_W-1:0] tnum_r;

  // block state
  logic signed [7:0]       prev_day_r;
  logic signed [7:0]       prev_night_r;
  logic signed [7:0]       des_day_r;
  logic signed [7:0]       des_night_r;
  logic signed [7:0]       last_tgt_r;
  logic signed [7:0]       last_out_r;

  // result register
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [7:0]       out_tgt_r;
  logic signed [7:0]       out_day_r;
  logic signed [7:0]       out_night_r;
  logic signed [7:0]       out_out_r;
  logic                    out_free;

  // datapath
  logic signed [31:0]      q32;
  logic signed [7:0]       outside_v;
  logic signed [7:0]       day_v;
  logic signed [7:0]       night_v;
  logic signed [7:0]       desired;
  logic signed [8:0]       diff;
  logic signed [TGT_W-1:0] prod;
  logic signed [TGT_W-1:0] tnum_v;
  logic signed [7:0]       tq;
  logic signed [7:0]       wmin;
  logic signed [7:0]       wmax;
  logic signed [7:0]       tgt_v;

  assign {h_func, h_night, h_set_day, h_set_night, h_num_out, h_num_day, h_num_night} = q_data;

  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = h_func ? ST_EMIT : ST_CONV1;
        end
      end
      ST_CONV1: state_nxt = ST_CONV2;
      ST_CONV2: state_nxt = ST_CONV3;
      ST_CONV3: state_nxt = ST_CONV4;
      ST_CONV4: state_nxt = ST_CONV5;
      ST_CONV5: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_TDIV;
      ST_TDIV:  state_nxt = ST_TW1;
      ST_TW1:   state_nxt = ST_TW2;
      ST_TW2:   state_nxt = ST_TDONE;
      ST_TDONE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controls; divider results are read back from the divider's output register
  always_comb begin
    ctl = '{pop: 1'b0, ld_set: 1'b0, src: SRC_HEAD, sel: DIV_CONV, ld_outside: 1'b0,
            ld_day: 1'b0, ld_night: 1'b0, ld_tnum: 1'b0, ld_target: 1'b0, ld_out: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        ctl.pop    = !q_empty;
        ctl.ld_set = !q_empty && h_func;
      end
      ST_CONV1: ctl.src = SRC_DAY;
      ST_CONV2: ctl.src = SRC_NIGHT;
      ST_CONV3: ctl.ld_outside = 1'b1;
      ST_CONV4: ctl.ld_day = 1'b1;
      ST_CONV5: ctl.ld_night = 1'b1;
      ST_MULT:  ctl.ld_tnum = 1'b1;
      ST_TDIV: begin
        ctl.src = SRC_CURVE;
        ctl.sel = DIV_CURVE;
      end
      ST_TW1, ST_TW2: begin
      end
      ST_TDONE: ctl.ld_target = 1'b1;
      ST_EMIT:  ctl.ld_out = out_free;
      default: begin
      end
    endcase
  end

  assign q_pop   = ctl.pop;
  assign div_sel = ctl.sel;

  // divider operand
  always_comb begin
    case (ctl.src)
      SRC_HEAD:  div_x = DIV_W'($signed(h_num_out));
      SRC_DAY:   div_x = DIV_W'($signed(cur_num_day_r));
      SRC_NIGHT: div_x = DIV_W'($signed(cur_num_night_r));
      SRC_CURVE: div_x = DIV_W'(tnum_r);
      default:   div_x = DIV_W'(tnum_r);
    endcase
  end

  // conversions
  assign q32       = 32'(div_q);
  assign outside_v = sat8(q32);
  assign day_v     = sat8(q32 + 32'($signed(cfg.tref)));
  assign night_v   = sat8(32'(day_r) - q32);

  // curve numerator
  assign desired = cur_night_r ? des_night_r : des_day_r;
  assign diff    = 9'(desired) - 9'(last_out_r);
  assign prod    = TGT_W'($signed({1'b0, cfg.coef})) * TGT_W'(diff);
  assign tnum_v  = prod + TGT_W'($signed({1'b0, cfg.shift}));

  // saturate, then clamp with the minimum tested first
  assign tq   = sat8(q32);
  assign wmin = $signed(cfg.wmin);
  assign wmax = $signed(cfg.wmax);
  always_comb begin
    tgt_v = tq;
    if (tq < wmin) begin
      tgt_v = wmin;
    end else if (tq > wmax) begin
      tgt_v = wmax;
    end
  end

  assign out_valid_nxt = ctl.ld_out ? 1'b1 : (pop ? 1'b0 : out_valid_r);

  // control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_day_r   <= '0;
      prev_night_r <= '0;
      des_day_r    <= '0;
      des_night_r  <= '0;
      last_tgt_r   <= '0;
      last_out_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctl.ld_set) begin
        des_day_r   <= $signed(h_set_day);
        des_night_r <= $signed(h_set_night);
      end
      if (ctl.ld_outside) begin
        last_out_r <= outside_v;
      end
      // desired values follow the trimmers only when they move
      if (ctl.ld_night) begin
        if (day_r != prev_day_r) begin
          des_day_r  <= day_r;
          prev_day_r <= day_r;
        end
        if (night_v != prev_night_r) begin
          des_night_r  <= night_v;
          prev_night_r <= night_v;
        end
      end
      if (ctl.ld_target) begin
        last_tgt_r <= tgt_v;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_night_r     <= h_night;
      cur_num_day_r   <= h_num_day;
      cur_num_night_r <= h_num_night;
    end
    if (ctl.ld_day) begin
      day_r <= day_v;
    end
    if (ctl.ld_tnum) begin
      tnum_r <= tnum_v;
    end
    if (ctl.ld_out) begin
      out_tgt_r   <= last_tgt_r;
      out_day_r   <= des_day_r;
      out_night_r <= des_night_r;
      out_out_r   <= last_out_r;
    end
  end

  assign out_water_target  = out_tgt_r;
  assign out_day_desired   = out_day_r;
  assign out_night_desired = out_night_r;
  assign out_outside_temp  = out_out_r;

endmodule

`default_nettype wire

// File: design/heating_curve_water_target_top.sv
// Heating curve water target.
// Input side is a queue: drive the item fields and push; the item is taken at
// a clock edge with push high and full low. Func 0 converts the three ADC
// samples, updates the desired day/night values when a trimmer moves and
// computes a new clamped water target; func 1 loads both desired values.
// Result side is a queue too: the oldest result is on the out_ ports while
// empty is low and leaves at an edge with pop high and empty low.
// An update item walks the sequencer through the conversion, multiply,
// curve-divide and emit states; a set item goes straight to emit. The
// sequencer takes one item at a time from the queue, walking it through one
// shared 3-stage constant divider (three sensor lines, then the curve).
// A 2-entry input queue and a 1-entry result register decouple the sides:
// while pop stays low the sequencer holds its finished result, the queue
// fills and full rises.
// Configuration: cfg_we with cfg_index and cfg_data, taken in the same cycle;
// write only while the block is idle. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// desired values, trimmer history and last results, and empties both queues.
`default_nettype none

module heating_curve_water_target_top
  import hcwt_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_func,
  input  wire logic [ADC_BITS-1:0]   in_outside_adc,
  input  wire logic [ADC_BITS-1:0]   in_day_trim_adc,
  input  wire logic [ADC_BITS-1:0]   in_night_trim_adc,
  input  wire logic                  in_night_mode,
  input  wire logic signed [7:0]     in_set_day,
  input  wire logic signed [7:0]     in_set_night,
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [7:0]          out_water_target,
  output logic signed [7:0]          out_day_desired,
  output logic signed [7:0]          out_night_desired,
  output logic signed [7:0]          out_outside_temp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_W = num_width(ADC_BITS);
  localparam int DIV_W = div_width(NUM_W);
  localparam int ENT_W = ent_width(NUM_W);

  cfg_t                     cfg_r;
  cfg_t                     cfg_nxt;
  logic                     q_wr;
  logic                     q_full;
  logic [ENT_W-1:0]         q_wr_data;
  logic                     q_pop;
  logic [ENT_W-1:0]         q_rd_data;
  logic                     q_empty;
  logic signed [DIV_W-1:0]  div_x;
  div_sel_t                 div_sel;
  logic signed [DIV_W-1:0]  div_q;

  // configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF:  cfg_nxt.coef  = cfg_data;
        CFG_SHIFT: cfg_nxt.shift = cfg_data;
        CFG_TREF:  cfg_nxt.tref  = cfg_data[7:0];
        CFG_WMIN:  cfg_nxt.wmin  = cfg_data[7:0];
        CFG_WMAX:  cfg_nxt.wmax  = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{coef: COEF_RST, shift: SHIFT_RST, tref: TREF_RST,
                 wmin: WMIN_RST, wmax: WMAX_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hcwt_front #(
    .ADC_BITS (ADC_BITS),
    .NUM_W    (NUM_W)
  ) u_front (
    .push              (push),
    .full              (full),
    .in_func           (in_func),
    .in_outside_adc    (in_outside_adc),
    .in_day_trim_adc   (in_day_trim_adc),
    .in_night_trim_adc (in_night_trim_adc),
    .in_night_mode     (in_night_mode),
    .in_set_day        (in_set_day),
    .in_set_night      (in_set_night),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_data            (q_wr_data)
  );

  hcwt_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  hcwt_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk (clk),
    .sel (div_sel),
    .x   (div_x),
    .q   (div_q)
  );

  hcwt_back #(
    .NUM_W (NUM_W),
    .DIV_W (DIV_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .div_x             (div_x),
    .div_sel           (div_sel),
    .div_q             (div_q),
    .empty             (empty),
    .pop               (pop),
    .out_water_target  (out_water_target),
    .out_day_desired   (out_day_desired),
    .out_night_desired (out_night_desired),
    .out_outside_temp  (out_outside_temp)
  );

endmodule

`default_nettype wire
